// ----- src/fbp_pkg.sv -----
// flat-bottom power bond package: shared constants, types and helper functions
// used by the multiplier, square root and top-level sequencer; no dependencies
`timescale 1ns / 1ps
package fbp_pkg;

    localparam int NUM_TYPES = 8;
    localparam int MAX_POWER = 8;
    localparam int FRAC_BITS = 16;
    localparam int TYPE_W    = 3;
    localparam int POW_W     = 4;

    localparam logic [63:0] SAT_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q   = 64'(1) << FRAC_BITS;

    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_VSHRT = 3'd1;
    localparam logic [2:0] ST_VLONG = 3'd2;
    localparam logic [2:0] ST_SERR  = 3'd3;
    localparam logic [2:0] ST_LERR  = 3'd4;
    localparam logic [2:0] ST_SAT   = 3'd5;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // request to the shared multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic        a_ov;
        logic [63:0] b;
        logic        b_ov;
        logic        sh_f;
        logic        neg_cap;
    } t_mul_req;

    // response from the shared multiplier
    typedef struct packed {
        logic        done;
        logic [63:0] v;
        logic        ov;
    } t_mul_rsp;

    // magnitude of a signed 32-bit value
    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    // n^(n+1), the energy prefactor
    function automatic logic [63:0] coef_e(input logic [POW_W-1:0] n);
        case (n)
            4'd1:    coef_e = 64'd1;
            4'd2:    coef_e = 64'd8;
            4'd3:    coef_e = 64'd81;
            4'd4:    coef_e = 64'd1024;
            4'd5:    coef_e = 64'd15625;
            4'd6:    coef_e = 64'd279936;
            4'd7:    coef_e = 64'd5764801;
            4'd8:    coef_e = 64'd134217728;
            default: coef_e = 64'd0;
        endcase
    endfunction

    // n^(n+2), the force prefactor
    function automatic logic [63:0] coef_f(input logic [POW_W-1:0] n);
        case (n)
            4'd1:    coef_f = 64'd1;
            4'd2:    coef_f = 64'd16;
            4'd3:    coef_f = 64'd243;
            4'd4:    coef_f = 64'd4096;
            4'd5:    coef_f = 64'd78125;
            4'd6:    coef_f = 64'd1679616;
            4'd7:    coef_f = 64'd40353607;
            4'd8:    coef_f = 64'd1073741824;
            default: coef_f = 64'd0;
        endcase
    endfunction

endpackage

// ----- src/fbp_mul.sv -----
// shared saturating 64x64 multiplier, one 32x32 partial product per cycle
// depends on fbp_pkg
`timescale 1ns / 1ps
module fbp_mul
    import fbp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic         r_busy, n_busy;
    logic         r_post, n_post;
    logic         r_done, n_done;
    logic [1:0]   r_step, n_step;
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_a, n_a, r_b, n_b;
    logic         r_sh, n_sh, r_neg, n_neg;
    logic [63:0]  r_v, n_v;
    logic         r_ov, n_ov;

    logic [31:0]  pa, pb;
    logic [63:0]  pp;
    logic [6:0]   psh;
    logic [127:0] shifted;
    logic [63:0]  cap, res;
    logic         over;

    // partial product operand select
    always_comb begin
        case (r_step)
            2'd0:    begin pa = r_a[31:0];  pb = r_b[31:0];  psh = 7'd0;  end
            2'd1:    begin pa = r_a[31:0];  pb = r_b[63:32]; psh = 7'd32; end
            2'd2:    begin pa = r_a[63:32]; pb = r_b[31:0];  psh = 7'd32; end
            default: begin pa = r_a[63:32]; pb = r_b[63:32]; psh = 7'd64; end
        endcase
        pp = 64'(pa) * 64'(pb);
    end

    // truncate and saturate the full product
    always_comb begin
        shifted = r_sh ? (r_acc >> FRAC_BITS) : r_acc;
        cap     = r_neg ? NEG_CAP : SAT_CAP;
        over    = (shifted[127:64] != 64'd0) || (shifted[63:0] > cap);
        res     = over ? cap : shifted[63:0];
    end

    // sequencing
    always_comb begin
        n_busy = r_busy; n_post = 1'b0; n_done = 1'b0; n_step = r_step;
        n_acc = r_acc; n_a = r_a; n_b = r_b; n_sh = r_sh; n_neg = r_neg;
        n_v = r_v; n_ov = r_ov;
        if (i_req.start) begin
            if ((i_req.a == 64'd0 && !i_req.a_ov) || (i_req.b == 64'd0 && !i_req.b_ov)) begin
                n_v = 64'd0; n_ov = 1'b0; n_done = 1'b1;
            end else if (i_req.a_ov || i_req.b_ov) begin
                n_v = SAT_CAP; n_ov = 1'b1; n_done = 1'b1;
            end else begin
                n_busy = 1'b1; n_step = 2'd0; n_acc = 128'd0;
                n_a = i_req.a; n_b = i_req.b; n_sh = i_req.sh_f; n_neg = i_req.neg_cap;
            end
        end else if (r_busy) begin
            n_acc  = r_acc + (128'(pp) << psh);
            n_step = r_step + 2'd1;
            if (r_step == 2'd3) begin
                n_busy = 1'b0; n_post = 1'b1;
            end
        end else if (r_post) begin
            n_v = res; n_ov = over; n_done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_post <= 1'b0; r_done <= 1'b0; r_step <= 2'd0;
        end else begin
            r_busy <= n_busy; r_post <= n_post; r_done <= n_done; r_step <= n_step;
        end
        r_acc <= n_acc; r_a <= n_a; r_b <= n_b; r_sh <= n_sh; r_neg <= n_neg;
        r_v <= n_v; r_ov <= n_ov;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.v    = r_v;
    assign o_rsp.ov   = r_ov;

    // a new product is never requested while one is in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && !r_post)
        else $error("multiplier restarted while busy");

endmodule

// ----- src/fbp_sqrt.sv -----
// iterative floor square root of a 64-bit value, two radicand bits per cycle
// depends on fbp_pkg only by convention (imports it but uses none of its items)
`timescale 1ns / 1ps
module fbp_sqrt
    import fbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, n_busy, r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_x, n_x, r_res, n_res, r_x0, n_x0;
    logic [63:0] bitv;
    logic [64:0] trial;

    // one digit step
    always_comb begin
        bitv  = 64'(1) << {r_cnt, 1'b0};
        trial = {1'b0, r_res} + {1'b0, bitv};
        n_busy = r_busy; n_done = 1'b0; n_cnt = r_cnt;
        n_x = r_x; n_res = r_res; n_x0 = r_x0;
        if (i_start) begin
            n_busy = 1'b1; n_cnt = 5'd31; n_x = i_x; n_x0 = i_x; n_res = 64'd0;
        end else if (r_busy) begin
            if ({1'b0, r_x} >= trial) begin
                n_x   = r_x - trial[63:0];
                n_res = (r_res >> 1) + bitv;
            end else begin
                n_res = r_res >> 1;
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= 5'd0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_x <= n_x; r_res <= n_res; r_x0 <= n_x0;
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

    // the root never overshoots the radicand
    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (64'(o_root) * 64'(o_root)) <= r_x0)
        else $error("square root too large");

endmodule

// ----- src/flat_bottom_power_bond_force.sv -----
// flat-bottom power bond evaluator, top level: coefficient tables and sequencer
// depends on fbp_pkg, fbp_mul and fbp_sqrt
`timescale 1ns / 1ps
// Usage:
//   Input words arrive on the s channel. tuser bit 0 is op: a write stores one
//   bond type's stiffness, limits and exponent and gives no result; an
//   evaluation gives one word on the m channel with status in tuser and
//   energy, force scalar and force vector in tdata.
//   An evaluation runs three squares, a 32-step square root and up to
//   2*(n+4) products plus three force products on one shared multiplier.
//   A product with nonzero operands passes through request, four 32x32
//   partials, saturation and handoff; one with a zero operand is answered
//   without the partials.
//   s_tready is high only while no evaluation is in progress.
//   The result sits in an output register; a stalled receiver holds the block
//   at its final step until that register frees, the result is never lost.
//   Reset clears all limits and stiffness to zero and every exponent to one,
//   so any nonzero length evaluates as a long error until written.
module flat_bottom_power_bond_force
    import fbp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // sep_x, sep_y, sep_z, coef_stiffness, coef_lower, coef_upper, coef_power
    input  logic [199:0] i_s_tdata,
    // op, bond_type
    input  logic [3:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // energy, force_scalar, force_x, force_y, force_z
    output logic [319:0] o_m_tdata,
    // status
    output logic [2:0]   o_m_tuser
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_SQRT = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_TERM = 4'd4;
    localparam logic [3:0] S_POW  = 4'd5;
    localparam logic [3:0] S_KE   = 4'd6;
    localparam logic [3:0] S_CE   = 4'd7;
    localparam logic [3:0] S_KF   = 4'd8;
    localparam logic [3:0] S_CF   = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_FRC  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // input unpacking
    logic              in_op;
    logic [TYPE_W-1:0] in_type;
    logic [POW_W-1:0]  in_pow;
    logic              acc_in;
    assign in_op   = i_s_tuser[0];
    assign in_type = i_s_tuser[3:1];
    assign in_pow  = i_s_tdata[195:192];
    assign acc_in  = i_s_tvalid && o_s_tready;

    // coefficient tables
    logic [31:0]      r_k_tab  [NUM_TYPES];
    logic [31:0]      r_lo_tab [NUM_TYPES];
    logic [31:0]      r_up_tab [NUM_TYPES];
    logic [POW_W-1:0] r_n_tab  [NUM_TYPES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                r_k_tab[i] <= 32'd0; r_lo_tab[i] <= 32'd0;
                r_up_tab[i] <= 32'd0; r_n_tab[i] <= POW_W'(1);
            end
        end else if (acc_in && in_op == OP_WRITE
                     && {1'b0, in_type} < (TYPE_W + 1)'(NUM_TYPES)) begin
            r_k_tab[in_type]  <= i_s_tdata[127:96];
            r_lo_tab[in_type] <= i_s_tdata[159:128];
            r_up_tab[in_type] <= i_s_tdata[191:160];
            r_n_tab[in_type]  <= (in_pow > POW_W'(MAX_POWER)) ? POW_W'(MAX_POWER) : in_pow;
        end
    end

    // sequencer registers
    logic [3:0]       r_state, n_state;
    logic             r_pend, n_pend;
    logic [3:0]       r_cnt, n_cnt;
    logic [31:0]      r_sep [3];
    logic [31:0]      r_k, r_lc1, r_lc0;
    logic [POW_W-1:0] r_n;
    logic [63:0]      r_sum, n_sum;
    logic [31:0]      r_l, n_l;
    logic             r_term, n_term;
    logic [32:0]      r_d, n_d;
    logic [63:0]      r_dp, n_dp, r_dpm1, n_dpm1, r_t, n_t;
    logic             r_dp_ov, n_dp_ov, r_dpm1_ov, n_dpm1_ov, r_t_ov, n_t_ov;
    logic [63:0]      r_e [2];
    logic [63:0]      r_f [2];
    logic             r_e_ov [2];
    logic             r_f_ov [2];
    logic [62:0]      r_energy;
    logic [63:0]      r_fs;
    logic [63:0]      r_fv [3];
    logic             r_sat;
    logic [2:0]       r_status;
    logic             r_ovalid;
    logic [319:0]     r_odata;
    logic [2:0]       r_ouser;

    t_mul_req mreq;
    t_mul_rsp mrsp;
    logic     sq_start, sq_done;
    logic [31:0] sq_root;

    fbp_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));
    fbp_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sq_start), .i_x(r_sum),
                     .o_done(sq_done), .o_root(sq_root));

    // range checks on the length, force sign and magnitude, and the energy sum
    logic        short_on, long_on, term_on;
    logic [33:0] l4, lc0_4;
    logic [32:0] l2, lc0_2;
    logic [31:0] smag;
    logic        fneg;
    logic [63:0] fmag;
    logic [64:0] esum;
    logic        e_over;
    always_comb begin
        short_on = r_l < r_lc1;
        long_on  = r_l > r_lc0;
        term_on  = r_term ? long_on : short_on;
        l4    = {r_l, 2'b00};
        lc0_4 = {r_lc0, 2'b00};
        l2    = {r_l, 1'b0};
        lc0_2 = {r_lc0, 1'b0};
        smag  = mag32(r_sep[r_cnt[1:0]]);
        fneg  = r_fs[63] ^ r_sep[r_cnt[1:0]][31];
        fmag  = r_fs[63] ? (64'd0 - r_fs) : r_fs;
        esum  = {1'b0, r_e[0]} + {1'b0, r_e[1]};
        e_over = r_e_ov[0] || r_e_ov[1] || esum > 65'(SAT_CAP);
    end

    // multiplier operand select
    always_comb begin
        mreq = '0;
        mreq.start = !r_pend && (r_state == S_SQ || r_state == S_POW || r_state == S_KE
                     || r_state == S_CE || r_state == S_KF || r_state == S_CF
                     || r_state == S_FRC);
        case (r_state)
            S_SQ: begin
                mreq.a = 64'(smag); mreq.b = 64'(smag);
            end
            S_POW: begin
                mreq.a = r_dp; mreq.a_ov = r_dp_ov; mreq.b = 64'(r_d); mreq.sh_f = 1'b1;
            end
            S_KE: begin
                mreq.a = 64'(r_k); mreq.b = r_dp; mreq.b_ov = r_dp_ov; mreq.sh_f = 1'b1;
            end
            S_CE: begin
                mreq.a = r_t; mreq.a_ov = r_t_ov; mreq.b = coef_e(r_n);
            end
            S_KF: begin
                mreq.a = 64'(r_k); mreq.b = r_dpm1; mreq.b_ov = r_dpm1_ov; mreq.sh_f = 1'b1;
            end
            S_CF: begin
                mreq.a = r_t; mreq.a_ov = r_t_ov; mreq.b = coef_f(r_n);
            end
            S_FRC: begin
                mreq.a = fmag; mreq.b = 64'(smag); mreq.sh_f = 1'b1; mreq.neg_cap = fneg;
            end
            default: mreq.a = 64'd0;
        endcase
    end

    assign sq_start = (r_state == S_SQRT) && !r_pend;
    assign o_s_tready = (r_state == S_IDLE);

    // state sequencing
    always_comb begin
        n_state = r_state; n_pend = r_pend; n_cnt = r_cnt; n_sum = r_sum; n_l = r_l;
        n_term = r_term; n_d = r_d; n_dp = r_dp; n_dp_ov = r_dp_ov;
        n_dpm1 = r_dpm1; n_dpm1_ov = r_dpm1_ov; n_t = r_t; n_t_ov = r_t_ov;
        if (mreq.start || sq_start) n_pend = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (acc_in && in_op == OP_EVAL) begin
                    n_sum = 64'd0; n_cnt = 4'd0;
                    n_state = ({1'b0, in_type} < (TYPE_W + 1)'(NUM_TYPES)) ? S_SQ : S_OUT;
                end
            end
            S_SQ: if (mrsp.done) begin
                n_pend = 1'b0; n_sum = r_sum + mrsp.v; n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) n_state = S_SQRT;
            end
            S_SQRT: if (sq_done) begin
                n_pend = 1'b0; n_l = sq_root; n_state = S_CHK;
            end
            S_CHK: begin
                n_term = 1'b0;
                if (short_on && l4 <= 34'(r_lc1)) n_state = S_OUT;
                else if (long_on && 34'(r_l) >= lc0_4) n_state = S_OUT;
                else n_state = S_TERM;
            end
            S_TERM: begin
                if (!term_on || r_n == POW_W'(0)) begin
                    if (r_term) n_state = S_SUM;
                    n_term = 1'b1;
                end else begin
                    n_d = r_term ? (33'(r_l) - 33'(r_lc0)) : (33'(r_lc1) - 33'(r_l));
                    n_dp = ONE_Q; n_dp_ov = 1'b0; n_cnt = 4'd0; n_state = S_POW;
                end
            end
            S_POW: if (mrsp.done) begin
                n_pend = 1'b0;
                if (r_cnt == 4'(r_n) - 4'd1) begin
                    n_dpm1 = r_dp; n_dpm1_ov = r_dp_ov; n_state = S_KE;
                end
                n_dp = mrsp.v; n_dp_ov = mrsp.ov; n_cnt = r_cnt + 4'd1;
            end
            S_KE: if (mrsp.done) begin
                n_pend = 1'b0; n_t = mrsp.v; n_t_ov = mrsp.ov; n_state = S_CE;
            end
            S_CE: if (mrsp.done) begin
                n_pend = 1'b0; n_state = S_KF;
            end
            S_KF: if (mrsp.done) begin
                n_pend = 1'b0; n_t = mrsp.v; n_t_ov = mrsp.ov; n_state = S_CF;
            end
            S_CF: if (mrsp.done) begin
                n_pend = 1'b0; n_term = 1'b1;
                n_state = r_term ? S_SUM : S_TERM;
            end
            S_SUM: begin
                n_cnt = 4'd0; n_state = S_FRC;
            end
            S_FRC: if (mrsp.done) begin
                n_pend = 1'b0; n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd2) n_state = S_OUT;
            end
            S_OUT: if (!r_ovalid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pend <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_pend <= n_pend;
            if (r_state == S_OUT && (!r_ovalid || i_m_tready)) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt; r_sum <= n_sum; r_l <= n_l; r_term <= n_term; r_d <= n_d;
        r_dp <= n_dp; r_dp_ov <= n_dp_ov; r_dpm1 <= n_dpm1; r_dpm1_ov <= n_dpm1_ov;
        r_t <= n_t; r_t_ov <= n_t_ov;
        case (r_state)
            S_IDLE: if (acc_in) begin
                r_sep[0] <= i_s_tdata[31:0];
                r_sep[1] <= i_s_tdata[63:32];
                r_sep[2] <= i_s_tdata[95:64];
                r_k   <= r_k_tab[in_type];
                r_lc1 <= r_lo_tab[in_type];
                r_lc0 <= r_up_tab[in_type];
                r_n   <= r_n_tab[in_type];
                r_energy <= 63'd0; r_fs <= 64'd0;
                r_fv[0] <= 64'd0; r_fv[1] <= 64'd0; r_fv[2] <= 64'd0;
                r_sat <= 1'b0; r_status <= ST_OK;
                r_e[0] <= 64'd0; r_e[1] <= 64'd0; r_f[0] <= 64'd0; r_f[1] <= 64'd0;
                r_e_ov[0] <= 1'b0; r_e_ov[1] <= 1'b0;
                r_f_ov[0] <= 1'b0; r_f_ov[1] <= 1'b0;
            end
            S_CHK: begin
                if (short_on && l4 <= 34'(r_lc1)) r_status <= ST_SERR;
                else if (long_on && 34'(r_l) >= lc0_4) r_status <= ST_LERR;
            end
            S_CE: if (mrsp.done) begin
                r_e[r_term] <= mrsp.v; r_e_ov[r_term] <= mrsp.ov;
            end
            S_CF: if (mrsp.done) begin
                r_f[r_term] <= mrsp.v; r_f_ov[r_term] <= mrsp.ov;
            end
            S_SUM: begin
                r_energy <= e_over ? SAT_CAP[62:0] : esum[62:0];
                r_sat    <= e_over || r_f_ov[0] || r_f_ov[1];
                r_fs     <= r_f[0] - r_f[1];
            end
            S_FRC: if (mrsp.done) begin
                r_fv[r_cnt[1:0]] <= fneg ? (64'd0 - mrsp.v) : mrsp.v;
                if (mrsp.ov) r_sat <= 1'b1;
                if (r_cnt == 4'd2) begin
                    if (r_sat || mrsp.ov) r_status <= ST_SAT;
                    else if (short_on && 33'(r_lc1) >= l2) r_status <= ST_VSHRT;
                    else if (long_on && 33'(r_l) >= lc0_2) r_status <= ST_VLONG;
                end
            end
            default: r_sat <= r_sat;
        endcase
        if (r_state == S_OUT && (!r_ovalid || i_m_tready)) begin
            r_odata <= {1'b0, r_fv[2], r_fv[1], r_fv[0], r_fs, r_energy};
            r_ouser <= r_status;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // an error result carries no energy or force
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_ouser == ST_SERR || r_ouser == ST_LERR) |-> r_odata == 320'd0)
        else $error("error result with nonzero payload");

    // the square root only runs after the sum of squares is complete
    a_sqrt_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> $past(r_state) == S_SQ)
        else $error("square root started out of sequence");

    // the multiplier answers only while a product is pending
    a_mul_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mrsp.done |-> r_pend)
        else $error("multiplier result with nothing pending");

endmodule
